/* src/bps_pkg.sv */
// shared types and constants for the bitonic peak search core
package bps_pkg;

    localparam int VALUE_W = 32;
    localparam int PEAK_W  = 14;

    // one incoming array element
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    // one search result
    typedef struct packed {
        logic [PEAK_W-1:0] peak_index;
        logic              overflow;
    } result_t;

endpackage

/* src/bps_store.sv */
// element store: one write port, one read port, registered read data
module bps_store
    import bps_pkg::*;
#(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic signed [VALUE_W-1:0] wr_data,
    input  logic [AW-1:0]             rd_addr,
    output logic signed [VALUE_W-1:0] rd_data
);

    logic signed [VALUE_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/bps_search.sv */
// search sequencer: galloping probe then binary search over the store
module bps_search
    import bps_pkg::*;
#(
    parameter int MAX_LEN = 16384
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [$clog2(MAX_LEN+1)-1:0]         count,
    output logic [$clog2(MAX_LEN)-1:0]           rd_addr,
    input  logic signed [VALUE_W-1:0]            rd_data,
    output logic                                 done,
    output logic [$clog2(MAX_LEN)-1:0]           index
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCHK,
        S_GRD1,
        S_GCMP,
        S_BCHK,
        S_BRD1,
        S_BRD2,
        S_BDEC
    } state_t;

    state_t                    state_reg;
    logic [PW-1:0]             probe_reg;
    logic [CW-1:0]             n_reg;
    logic [AW-1:0]             lo_reg;
    logic [AW-1:0]             hi_reg;
    logic [AW-1:0]             mid_reg;
    logic                      pair_reg;
    logic signed [VALUE_W-1:0] w0_reg;
    logic signed [VALUE_W-1:0] w1_reg;
    logic                      done_reg;
    logic [AW-1:0]             index_reg;

    logic [PW-1:0]             probe_inc;
    logic                      probe_in_range;
    logic [PW-1:0]             probe_half;
    logic [AW-1:0]             gallop_lo;
    logic [AW:0]               lo_inc;
    logic [AW-1:0]             mid_c;
    logic                      done_next;

    // gallop bounds
    assign probe_inc      = probe_reg + PW'(1);
    assign probe_in_range = probe_inc < {1'b0, n_reg};
    assign probe_half     = probe_reg >> 1;
    assign gallop_lo      = (probe_half > PW'(hi_reg)) ? hi_reg : probe_half[AW-1:0];

    // span midpoint
    assign lo_inc = {1'b0, lo_reg} + (AW+1)'(1);
    assign mid_c  = lo_reg + ((hi_reg - lo_reg) >> 1);

    // a search ends on a settled span, a final pair or a peak at mid
    assign done_next = ((state_reg == S_BCHK) && (lo_reg >= hi_reg)) ||
                       ((state_reg == S_BRD2) && pair_reg) ||
                       ((state_reg == S_BDEC) && (w1_reg > w0_reg) && (w1_reg > rd_data));

    // read address for the current step
    always_comb
    begin
        rd_addr = '0;
        unique case (state_reg)
            S_GCHK:  rd_addr = probe_reg[AW-1:0];
            S_GRD1:  rd_addr = probe_inc[AW-1:0];
            S_BCHK:  rd_addr = (lo_inc == {1'b0, hi_reg}) ? lo_reg : mid_c - AW'(1);
            S_BRD1:  rd_addr = pair_reg ? hi_reg : mid_reg;
            S_BRD2:  rd_addr = mid_reg + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= count;
                        probe_reg <= PW'(1);
                        lo_reg    <= '0;
                        hi_reg    <= AW'(count - CW'(1));
                        state_reg <= S_GCHK;
                    end
                end
                S_GCHK:
                begin
                    if (probe_in_range)
                    begin
                        state_reg <= S_GRD1;
                    end
                    else
                    begin
                        lo_reg    <= gallop_lo;
                        state_reg <= S_BCHK;
                    end
                end
                S_GRD1:
                begin
                    w0_reg    <= rd_data;
                    state_reg <= S_GCMP;
                end
                S_GCMP:
                begin
                    if (w0_reg > rd_data)
                    begin
                        lo_reg    <= probe_half[AW-1:0];
                        hi_reg    <= probe_reg[AW-1:0];
                        state_reg <= S_BCHK;
                    end
                    else
                    begin
                        probe_reg <= probe_reg << 1;
                        state_reg <= S_GCHK;
                    end
                end
                S_BCHK:
                begin
                    if (lo_reg >= hi_reg)
                    begin
                        index_reg <= lo_reg;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        pair_reg  <= (lo_inc == {1'b0, hi_reg});
                        mid_reg   <= mid_c;
                        state_reg <= S_BRD1;
                    end
                end
                S_BRD1:
                begin
                    w0_reg    <= rd_data;
                    state_reg <= S_BRD2;
                end
                S_BRD2:
                begin
                    if (pair_reg)
                    begin
                        index_reg <= (w0_reg > rd_data) ? lo_reg : hi_reg;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        w1_reg    <= rd_data;
                        state_reg <= S_BDEC;
                    end
                end
                S_BDEC:
                begin
                    // w0 is mid-1, w1 is mid, read data is mid+1
                    if ((w1_reg > w0_reg) && (w1_reg > rd_data))
                    begin
                        index_reg <= mid_reg;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if ((w1_reg > rd_data) && (w0_reg > w1_reg))
                        begin
                            hi_reg <= mid_reg - AW'(1);
                        end
                        else
                        begin
                            lo_reg <= mid_reg + AW'(1);
                        end
                        state_reg <= S_BCHK;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign index = index_reg;

endmodule

/* src/bitonic_peak_search_core.sv */
// top level: element loading, search launch and result register
// throughput: one element per cycle while loading; no element is taken during
//   a search, which reads the element store one word at a time
// reset: rst_n clears element count, overflow flag and control; the store is
//   not cleared, only entries written for the current array are read
module bitonic_peak_search_core
    import bps_pkg::*;
#(
    parameter int MAX_LEN = 16384
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int EXT_W = AW + PEAK_W;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic               ovf_reg;
    logic               start_reg;
    logic [PEAK_W-1:0]  pend_idx_reg;
    logic               pend_ovf_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic               accept;
    logic               has_room;
    logic               wr_en;
    logic [AW-1:0]      rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    logic               srch_done;
    logic [AW-1:0]      srch_index;
    logic [EXT_W-1:0]   idx_ext;
    logic               slot_free;
    logic               emit;

    assign item_ready = (state_reg == ST_LOAD);
    assign accept     = item_valid && item_ready;
    assign has_room   = count_reg < CW'(MAX_LEN);
    assign wr_en      = accept && has_room;
    assign idx_ext    = {{PEAK_W{1'b0}}, srch_index};
    assign slot_free  = !result_valid_reg || result_ready;
    assign emit       = (state_reg == ST_EMIT) && slot_free;

    // element store
    bps_store #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (item.value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // search sequencer; loads and searches never overlap, so no forwarding
    bps_search #(
        .MAX_LEN (MAX_LEN)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .count   (count_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (srch_done),
        .index   (srch_index)
    );

    // load, search and emit control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            start_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept && item.last;
            if (result_ready && !emit)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (has_room)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (item.last)
                        begin
                            state_reg <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH:
                begin
                    if (srch_done)
                    begin
                        pend_idx_reg <= idx_ext[PEAK_W-1:0];
                        pend_ovf_reg <= ovf_reg;
                        count_reg    <= '0;
                        ovf_reg      <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        result_reg.peak_index <= pend_idx_reg;
                        result_reg.overflow   <= pend_ovf_reg;
                        result_valid_reg      <= 1'b1;
                        state_reg             <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* src/bps_checker.sv */
// port-level checker for the bitonic peak search core, with its bind
module bps_checker
    import bps_pkg::*;
#(
    parameter int MAX_LEN = 16384
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // a pending result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result request dropped before acceptance");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    // the last element stops loading while the search runs
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.last |=> !item_ready)
        else $error("element accepted during search");

    // a search takes time: no fresh result right after the last element
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.last |=> !$rose(result_valid))
        else $error("result appeared without a search");

    // the reported index lies inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(result.peak_index) < MAX_LEN))
        else $error("peak index outside the store");

endmodule

bind bitonic_peak_search_core bps_checker #(.MAX_LEN(MAX_LEN)) u_bps_checker (.*);
